>>> rtl/ptal_pkg.sv
// Shared constants, codes and types of the page word associative memory.
package ptal_pkg;

    localparam int ENTRIES    = 16;
    localparam int IDX_W      = $clog2(ENTRIES);
    localparam int USE_W      = IDX_W;
    localparam int SEG_W      = 15;
    localparam int OFF_W      = 18;
    localparam int PAGE_SHIFT = 6;
    localparam int PAGE_W     = OFF_W - PAGE_SHIFT;
    localparam int FRAME_W    = 18;
    localparam int OUT_IDX_W  = 4;

    localparam logic [PAGE_W-1:0] PAGE_MASK = PAGE_W'(12'o7760);
    localparam logic [USE_W-1:0]  USE_MAX   = USE_W'(ENTRIES - 1);

    // request codes
    localparam logic [1:0] REQ_LOOKUP = 2'd0;
    localparam logic [1:0] REQ_FILL   = 2'd1;
    localparam logic [1:0] REQ_FLUSH  = 2'd2;

    // configuration register indexes
    localparam logic CFG_WAM_ENABLE      = 1'b0;
    localparam logic CFG_PAGE_WAM_ENABLE = 1'b1;

    // update commands broadcast to every cell
    localparam logic [1:0] UPD_NONE  = 2'd0;
    localparam logic [1:0] UPD_TOUCH = 2'd1;
    localparam logic [1:0] UPD_FILL  = 2'd2;
    localparam logic [1:0] UPD_FLUSH = 2'd3;

    typedef struct packed {
        logic              fill;
        logic [SEG_W-1:0]  seg;
        logic [PAGE_W-1:0] page;
    } t_key;

    // search token that walks the chain one cell per cycle
    typedef struct packed {
        logic               active;
        logic               found;
        logic [IDX_W-1:0]   idx;
        logic [USE_W-1:0]   usage;
        logic [FRAME_W-1:0] frame;
        logic               used;
        logic               modified;
    } t_pkt;

    typedef struct packed {
        logic [1:0]         op;
        logic [IDX_W-1:0]   idx;
        logic [USE_W-1:0]   ref_usage;
        logic [SEG_W-1:0]   seg;
        logic [PAGE_W-1:0]  page;
        logic [FRAME_W-1:0] frame;
        logic               used;
        logic               modified;
    } t_upd;

endpackage

>>> rtl/ptal_cell.sv
// One entry of the associative memory: tags, page word, usage count and a token stage.
module ptal_cell import ptal_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_index,
    input  t_key             i_key,
    input  t_pkt             i_pkt,
    output t_pkt             o_pkt,
    input  t_upd             i_upd
);

    logic               r_valid;
    logic [USE_W-1:0]   r_usage;
    logic [SEG_W-1:0]   r_seg;
    logic [PAGE_W-1:0]  r_page;
    logic [FRAME_W-1:0] r_frame;
    logic               r_used;
    logic               r_modified;
    t_pkt               r_pkt;
    t_pkt               n_pkt;
    logic               w_take;
    logic               w_mine;

    always_comb begin
        if (i_key.fill) begin
            w_take = (r_usage == '0);
        end else begin
            w_take = r_valid && (r_seg == i_key.seg) && (r_page == i_key.page);
        end
    end

    // first taker along the chain claims the token
    always_comb begin
        n_pkt = i_pkt;
        if (i_pkt.active && !i_pkt.found && w_take) begin
            n_pkt.found    = 1'b1;
            n_pkt.idx      = i_index;
            n_pkt.usage    = r_usage;
            n_pkt.frame    = r_frame;
            n_pkt.used     = r_used;
            n_pkt.modified = r_modified;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pkt <= '0;
        end else begin
            r_pkt <= n_pkt;
        end
    end

    assign o_pkt  = r_pkt;
    assign w_mine = (i_upd.idx == i_index);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_usage <= i_index;
        end else begin
            unique case (i_upd.op)
                UPD_FLUSH: begin
                    r_valid <= 1'b0;
                    r_usage <= i_index;
                end
                UPD_TOUCH, UPD_FILL: begin
                    if (w_mine) begin
                        r_usage <= USE_MAX;
                    end else if (r_usage > i_upd.ref_usage) begin
                        r_usage <= r_usage - USE_W'(1);
                    end
                    if (i_upd.op == UPD_FILL && w_mine) begin
                        r_valid <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // tag and page word store: written on fill only
    always_ff @(posedge i_clk) begin
        if (i_upd.op == UPD_FILL && w_mine) begin
            r_seg      <= i_upd.seg;
            r_page     <= i_upd.page;
            r_frame    <= i_upd.frame;
            r_used     <= i_upd.used;
            r_modified <= i_upd.modified;
        end
    end

endmodule

>>> rtl/page_table_assoc_lookup.sv
// Top level: request control, cell chain, update broadcast and result register.
//
//  channel   valid        ready        payload
//  input     i_in_valid   o_in_ready   i_req_type i_segment i_word_offset i_fill_*
//  result    o_out_valid  i_out_ready  o_hit o_entry_index o_page_addr o_used o_modified
//  config    i_cfg_valid  o_cfg_ready  i_cfg_index i_cfg_data
//
// A lookup or fill sends a search token across the chain of ENTRIES cells, one cell per
// cycle; a register captures its findings, the apply state broadcasts the usage update
// and the done state registers the result. A flush goes straight to the apply state,
// type 3 and disabled requests to the done state. One item is in work at a time; the
// input is ready again once the result is registered, even while that result waits.
// Reset is synchronous: valid marks clear and usage counts load their index at once;
// no clearing pass follows.
module page_table_assoc_lookup import ptal_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_req_type,
    input  logic [SEG_W-1:0]     i_segment,
    input  logic [OFF_W-1:0]     i_word_offset,
    input  logic [FRAME_W-1:0]   i_fill_page_addr,
    input  logic                 i_fill_used,
    input  logic                 i_fill_modified,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_hit,
    output logic [OUT_IDX_W-1:0] o_entry_index,
    output logic [FRAME_W-1:0]   o_page_addr,
    output logic                 o_used,
    output logic                 o_modified,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic                 i_cfg_index,
    input  logic                 i_cfg_data
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_APPLY = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]         r_state;
    logic               r_wam_enable;
    logic               r_page_wam_enable;
    logic               r_launch;
    logic [1:0]         r_req_type;
    logic [SEG_W-1:0]   r_seg;
    logic [PAGE_W-1:0]  r_page;
    logic [FRAME_W-1:0] r_fill_frame;
    logic               r_fill_used;
    logic               r_fill_modified;
    logic               r_found;
    logic [IDX_W-1:0]   r_idx;
    logic [USE_W-1:0]   r_ref_usage;
    logic [FRAME_W-1:0] r_frame;
    logic               r_used;
    logic               r_modified;
    logic               r_out_valid;
    logic               r_hit;
    logic [OUT_IDX_W-1:0] r_entry_index;
    logic [FRAME_W-1:0] r_page_addr;
    logic               r_out_used;
    logic               r_out_modified;

    logic               w_in_acc;
    logic               w_on;
    logic               w_load;
    logic [PAGE_W-1:0]  w_page;
    logic [IDX_W+OUT_IDX_W-1:0] w_idx_ext;
    logic               w_lookup_hit;
    logic               w_show_idx;
    logic [ENTRIES-1:0] w_act;
    t_key               w_key;
    t_upd               w_upd;
    t_pkt               w_pkt [ENTRIES+1];

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_on       = r_wam_enable && r_page_wam_enable;
    assign w_page     = i_word_offset[OFF_W-1:PAGE_SHIFT] & PAGE_MASK;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wam_enable      <= 1'b0;
            r_page_wam_enable <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_WAM_ENABLE:      r_wam_enable      <= i_cfg_data;
                CFG_PAGE_WAM_ENABLE: r_page_wam_enable <= i_cfg_data;
            endcase
        end
    end

    // hold the item for the whole search
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_req_type      <= i_req_type;
            r_seg           <= i_segment;
            r_page          <= w_page;
            r_fill_frame    <= i_fill_page_addr;
            r_fill_used     <= i_fill_used;
            r_fill_modified <= i_fill_modified;
        end
    end

    assign w_key.fill = (r_req_type == REQ_FILL);
    assign w_key.seg  = r_seg;
    assign w_key.page = r_page;

    always_comb begin
        w_pkt[0]        = '0;
        w_pkt[0].active = r_launch;
    end

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        ptal_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (IDX_W'(g)),
            .i_key   (w_key),
            .i_pkt   (w_pkt[g]),
            .o_pkt   (w_pkt[g+1]),
            .i_upd   (w_upd)
        );
        assign w_act[g] = w_pkt[g+1].active;
    end

    assign w_load = (r_state == ST_DONE) && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_launch <= 1'b0;
            r_found  <= 1'b0;
        end else begin
            r_launch <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_found <= 1'b0;
                        if (w_on && (i_req_type == REQ_LOOKUP || i_req_type == REQ_FILL)) begin
                            r_launch <= 1'b1;
                            r_state  <= ST_SCAN;
                        end else if (w_on && i_req_type == REQ_FLUSH) begin
                            r_state <= ST_APPLY;
                        end else begin
                            r_state <= ST_DONE;
                        end
                    end
                end
                ST_SCAN: begin
                    if (w_pkt[ENTRIES].active) begin
                        r_found <= w_pkt[ENTRIES].found;
                        r_state <= ST_APPLY;
                    end
                end
                ST_APPLY: begin
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (w_load) begin
                        r_state <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    // capture the token's findings as it leaves the last cell
    always_ff @(posedge i_clk) begin
        if (r_state == ST_SCAN && w_pkt[ENTRIES].active) begin
            r_idx       <= w_pkt[ENTRIES].idx;
            r_ref_usage <= w_pkt[ENTRIES].usage;
            r_frame     <= w_pkt[ENTRIES].frame;
            r_used      <= w_pkt[ENTRIES].used;
            r_modified  <= w_pkt[ENTRIES].modified;
        end
    end

    always_comb begin
        w_upd.idx       = r_idx;
        w_upd.ref_usage = r_ref_usage;
        w_upd.seg       = r_seg;
        w_upd.page      = r_page;
        w_upd.frame     = r_fill_frame;
        w_upd.used      = r_fill_used;
        w_upd.modified  = r_fill_modified;
        w_upd.op        = UPD_NONE;
        if (r_state == ST_APPLY) begin
            priority if (r_req_type == REQ_FLUSH) begin
                w_upd.op = UPD_FLUSH;
            end else if (r_req_type == REQ_FILL && r_found) begin
                w_upd.op = UPD_FILL;
            end else if (r_req_type == REQ_LOOKUP && r_found) begin
                w_upd.op = UPD_TOUCH;
            end else begin
                // a miss leaves the table untouched
                w_upd.op = UPD_NONE;
            end
        end
    end

    assign w_lookup_hit = r_found && (r_req_type == REQ_LOOKUP);
    assign w_show_idx   = r_found && (r_req_type == REQ_LOOKUP || r_req_type == REQ_FILL);
    assign w_idx_ext    = {{OUT_IDX_W{1'b0}}, r_idx};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_hit          <= w_lookup_hit;
            r_entry_index  <= w_show_idx ? w_idx_ext[OUT_IDX_W-1:0] : '0;
            r_page_addr    <= w_lookup_hit ? r_frame : '0;
            r_out_used     <= w_lookup_hit && r_used;
            r_out_modified <= w_lookup_hit && r_modified;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_hit         = r_hit;
    assign o_entry_index = r_entry_index;
    assign o_page_addr   = r_page_addr;
    assign o_used        = r_out_used;
    assign o_modified    = r_out_modified;

    // at most one search token in the chain
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_act))
        else $error("more than one search token in the chain");

    a_token_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pkt[ENTRIES].active |-> (r_state == ST_SCAN))
        else $error("search token left the chain outside a scan");

    // usage counts form a permutation, so a fill always finds a victim
    a_fill_victim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pkt[ENTRIES].active && w_key.fill) |-> w_pkt[ENTRIES].found)
        else $error("fill found no entry with usage zero");

    a_apply_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_APPLY) |=> (r_state == ST_DONE))
        else $error("update broadcast did not end after one cycle");

endmodule
